// ===== rtl/core/bsa_pkg.sv =====
// shared types and constants for the three-resource banker's allocator
package bsa_pkg;

	localparam int MaxProcsDef  = 8;
	localparam int CountBitsDef = 8;
	localparam int NumRes       = 3;

	localparam int InitAvailR1 = 9;
	localparam int InitAvailR2 = 3;
	localparam int InitAvailR3 = 6;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_NO_PROC       = 3'd1,
		ST_EXCEEDS_NEED  = 3'd2,
		ST_EXCEEDS_AVAIL = 3'd3,
		ST_UNSAFE        = 3'd4,
		ST_ADMIT_SHORT   = 3'd5,
		ST_SLOT_BUSY     = 3'd6
	} status_t;

	typedef enum logic {
		FN_ADMIT   = 1'b0,
		FN_REQUEST = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		REG_INIT_R1 = 2'd0,
		REG_INIT_R2 = 2'd1,
		REG_INIT_R3 = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_CHECK,
		S_SCAN,
		S_COMMIT,
		S_RESULT
	} state_t;

endpackage

// ===== rtl/core/bankers_safe_allocator.sv =====
// banker's deadlock-avoidance allocator for three resource types, with a serial safety scan
// One item is in flight at a time; s_tready is high only while the sequencer is idle, and a
// finished result waits in an output register so the next item can be taken meanwhile. An
// item rejected by the slot, claim, need or available checks goes from S_CHECK straight to
// S_RESULT, and a granted admit passes through S_COMMIT first. A request that reaches the
// safety check runs a scan that reads one process slot per cycle from the allocation and
// need tables through a single compare-and-add unit; the scan stops at the end of a pass
// that made no progress or after which every slot has finished, so it runs between 1 and
// MAX_PROCS passes. A granted request then passes through S_COMMIT; an unsafe one goes
// straight to S_RESULT.
// Writing an initial-available register also reloads that available count at once.
module bankers_safe_allocator #(
	parameter int MAX_PROCS  = bsa_pkg::MaxProcsDef,
	parameter int COUNT_BITS = bsa_pkg::CountBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[2:0], amt_r1[10:3], amt_r2[18:11], amt_r3[26:19],
	// max_r1[34:27], max_r2[42:35], max_r3[50:43], zero pad[55:51]
	input  logic [55:0] s_tdata,
	// func[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], avail_r1[10:3], avail_r2[18:11], avail_r3[26:19], zero pad[31:27]
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NR     = bsa_pkg::NumRes;
	localparam int CB     = COUNT_BITS;
	localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int WORK_W = CB + $clog2(MAX_PROCS + 1);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_PROCS - 1);

	typedef logic [NR-1:0][CB-1:0] cvec_t;

	bsa_pkg::state_t state_q, state_nxt;

	// control
	logic [MAX_PROCS-1:0] slot_valid_q;
	logic [MAX_PROCS-1:0] done_q;
	logic                 m_tvalid_q;
	cvec_t                init_q;
	cvec_t                avail_q;
	logic                 progress_q;
	logic                 ev_vld_s1;
	logic [IDX_W-1:0]     ptr_q;

	// payload
	bsa_pkg::func_t       func_q;
	logic [2:0]           slot_q;
	cvec_t                amt_q;
	cvec_t                max_q;
	cvec_t                adj_alloc_q;
	cvec_t                adj_need_q;
	logic [NR-1:0][WORK_W-1:0] work_q;
	bsa_pkg::status_t     status_q;
	bsa_pkg::status_t     out_status_q;
	cvec_t                out_avail_q;
	logic [IDX_W-1:0]     ev_ptr_s1;
	cvec_t                rd_alloc_s1;
	cvec_t                rd_need_s1;

	logic [NR*CB-1:0] alloc_mem [MAX_PROCS];
	logic [NR*CB-1:0] need_mem  [MAX_PROCS];

	logic             cfg_wr;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic             in_range;
	logic             out_free;

	// check stage
	logic             max_cov;
	logic             avail_cov;
	logic             need_cov;
	bsa_pkg::status_t chk_status;

	// scan unit
	logic                      ev_self;
	cvec_t                     need_eff;
	cvec_t                     alloc_eff;
	logic                      fit;
	logic [NR-1:0][WORK_W-1:0] work_nxt;
	logic [MAX_PROCS-1:0]      done_nxt;
	logic                      pass_end;
	logic                      all_done;
	logic                      scan_fin;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign slot_idx = IDX_W'(slot_q);
	assign in_range = 32'(slot_q) < MAX_PROCS;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		unique case (bsa_pkg::cfg_reg_t'(paddr[3:2]))
			bsa_pkg::REG_INIT_R1: prdata = 32'(init_q[0]);
			bsa_pkg::REG_INIT_R2: prdata = 32'(init_q[1]);
			bsa_pkg::REG_INIT_R3: prdata = 32'(init_q[2]);
			default:              prdata = 32'd0;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, 8'(out_avail_q[2]), 8'(out_avail_q[1]), 8'(out_avail_q[0]),
		out_status_q};

	// per-item checks against the slot entry read during S_LOOK
	always_comb begin
		max_cov   = 1'b1;
		avail_cov = 1'b1;
		need_cov  = 1'b1;
		for (int r = 0; r < NR; r++) begin
			if (max_q[r] < amt_q[r])
				max_cov = 1'b0;
			if (avail_q[r] < amt_q[r])
				avail_cov = 1'b0;
			if (rd_need_s1[r] < amt_q[r])
				need_cov = 1'b0;
		end
		if (func_q == bsa_pkg::FN_ADMIT) begin
			priority if (!in_range)
				chk_status = bsa_pkg::ST_NO_PROC;
			else if (slot_valid_q[slot_idx])
				chk_status = bsa_pkg::ST_SLOT_BUSY;
			else if (!max_cov)
				chk_status = bsa_pkg::ST_EXCEEDS_NEED;
			else if (!avail_cov)
				chk_status = bsa_pkg::ST_ADMIT_SHORT;
			else
				chk_status = bsa_pkg::ST_OK;
		end else begin
			priority if (!in_range || !slot_valid_q[slot_idx])
				chk_status = bsa_pkg::ST_NO_PROC;
			else if (!need_cov)
				chk_status = bsa_pkg::ST_EXCEEDS_NEED;
			else if (!avail_cov)
				chk_status = bsa_pkg::ST_EXCEEDS_AVAIL;
			else
				chk_status = bsa_pkg::ST_OK;
		end
	end

	// shared compare-and-add unit, one slot per cycle
	always_comb begin
		ev_self   = ev_ptr_s1 == slot_idx;
		need_eff  = ev_self ? adj_need_q : rd_need_s1;
		alloc_eff = ev_self ? adj_alloc_q : rd_alloc_s1;
		fit       = ev_vld_s1 && !done_q[ev_ptr_s1];
		for (int r = 0; r < NR; r++) begin
			if (work_q[r] < WORK_W'(need_eff[r]))
				fit = 1'b0;
		end
		for (int r = 0; r < NR; r++)
			work_nxt[r] = fit ? work_q[r] + WORK_W'(alloc_eff[r]) : work_q[r];
		done_nxt = fit ? (done_q | (MAX_PROCS'(1) << ev_ptr_s1)) : done_q;
		pass_end = ev_vld_s1 && (ev_ptr_s1 == LAST);
		all_done = &done_nxt;
		scan_fin = pass_end && (!(progress_q || fit) || all_done);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bsa_pkg::S_IDLE:
				if (s_tvalid)
					state_nxt = bsa_pkg::S_LOOK;
			bsa_pkg::S_LOOK:
				state_nxt = bsa_pkg::S_CHECK;
			bsa_pkg::S_CHECK:
				priority if (chk_status != bsa_pkg::ST_OK)
					state_nxt = bsa_pkg::S_RESULT;
				else if (func_q == bsa_pkg::FN_ADMIT)
					state_nxt = bsa_pkg::S_COMMIT;
				else
					state_nxt = bsa_pkg::S_SCAN;
			bsa_pkg::S_SCAN:
				if (scan_fin)
					state_nxt = all_done ? bsa_pkg::S_COMMIT : bsa_pkg::S_RESULT;
			bsa_pkg::S_COMMIT:
				state_nxt = bsa_pkg::S_RESULT;
			bsa_pkg::S_RESULT:
				if (out_free)
					state_nxt = bsa_pkg::S_IDLE;
			default:
				state_nxt = bsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		rd_addr  = slot_idx;
		unique case (state_q)
			bsa_pkg::S_IDLE:   s_tready = 1'b1;
			bsa_pkg::S_SCAN:   rd_addr  = ptr_q;
			bsa_pkg::S_COMMIT: mem_we   = 1'b1;
			default:           rd_addr  = slot_idx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bsa_pkg::S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q[0]    <= CB'(bsa_pkg::InitAvailR1);
			init_q[1]    <= CB'(bsa_pkg::InitAvailR2);
			init_q[2]    <= CB'(bsa_pkg::InitAvailR3);
			avail_q[0]   <= CB'(bsa_pkg::InitAvailR1);
			avail_q[1]   <= CB'(bsa_pkg::InitAvailR2);
			avail_q[2]   <= CB'(bsa_pkg::InitAvailR3);
			slot_valid_q <= '0;
			done_q       <= '0;
			m_tvalid_q   <= 1'b0;
			progress_q   <= 1'b0;
			ev_vld_s1    <= 1'b0;
			ptr_q        <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (bsa_pkg::cfg_reg_t'(paddr[3:2]))
					bsa_pkg::REG_INIT_R1: begin
						init_q[0]  <= CB'(pwdata[7:0]);
						avail_q[0] <= CB'(pwdata[7:0]);
					end
					bsa_pkg::REG_INIT_R2: begin
						init_q[1]  <= CB'(pwdata[7:0]);
						avail_q[1] <= CB'(pwdata[7:0]);
					end
					bsa_pkg::REG_INIT_R3: begin
						init_q[2]  <= CB'(pwdata[7:0]);
						avail_q[2] <= CB'(pwdata[7:0]);
					end
					default: ;
				endcase
			end
			if (state_q == bsa_pkg::S_COMMIT) begin
				for (int r = 0; r < NR; r++)
					avail_q[r] <= avail_q[r] - amt_q[r];
				if (func_q == bsa_pkg::FN_ADMIT)
					slot_valid_q[slot_idx] <= 1'b1;
			end
			if (state_q == bsa_pkg::S_CHECK) begin
				done_q     <= ~slot_valid_q;
				progress_q <= 1'b0;
				ev_vld_s1  <= 1'b0;
				ptr_q      <= '0;
			end else if (state_q == bsa_pkg::S_SCAN) begin
				done_q     <= done_nxt;
				ev_vld_s1  <= 1'b1;
				ptr_q      <= (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
				progress_q <= pass_end ? 1'b0 : (progress_q || fit);
			end
			if (state_q == bsa_pkg::S_RESULT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bsa_pkg::S_IDLE && s_tvalid) begin
			func_q   <= bsa_pkg::func_t'(s_tuser[0]);
			slot_q   <= s_tdata[2:0];
			amt_q[0] <= CB'(s_tdata[10:3]);
			amt_q[1] <= CB'(s_tdata[18:11]);
			amt_q[2] <= CB'(s_tdata[26:19]);
			max_q[0] <= CB'(s_tdata[34:27]);
			max_q[1] <= CB'(s_tdata[42:35]);
			max_q[2] <= CB'(s_tdata[50:43]);
		end
		if (state_q == bsa_pkg::S_CHECK) begin
			status_q <= chk_status;
			for (int r = 0; r < NR; r++) begin
				work_q[r] <= WORK_W'(avail_q[r]) - WORK_W'(amt_q[r]);
				if (func_q == bsa_pkg::FN_ADMIT) begin
					adj_alloc_q[r] <= amt_q[r];
					adj_need_q[r]  <= max_q[r] - amt_q[r];
				end else begin
					adj_alloc_q[r] <= rd_alloc_s1[r] + amt_q[r];
					adj_need_q[r]  <= rd_need_s1[r] - amt_q[r];
				end
			end
		end
		if (state_q == bsa_pkg::S_SCAN) begin
			work_q    <= work_nxt;
			ev_ptr_s1 <= ptr_q;
			if (scan_fin)
				status_q <= all_done ? bsa_pkg::ST_OK : bsa_pkg::ST_UNSAFE;
		end
		if (state_q == bsa_pkg::S_RESULT && out_free) begin
			out_status_q <= status_q;
			out_avail_q  <= avail_q;
		end
	end

	// allocation and need tables
	always_ff @(posedge clk) begin
		if (mem_we) begin
			alloc_mem[slot_idx] <= adj_alloc_q;
			need_mem[slot_idx]  <= adj_need_q;
		end
		rd_alloc_s1 <= alloc_mem[rd_addr];
		rd_need_s1  <= need_mem[rd_addr];
	end

`ifndef SYNTHESIS
	a_avail_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr |=> (avail_q[0] <= $past(avail_q[0])) && (avail_q[1] <= $past(avail_q[1]))
			&& (avail_q[2] <= $past(avail_q[2])))
		else $error("available count grew without a register write");

	a_slots_never_freed: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (slot_valid_q & $past(slot_valid_q)) == $past(slot_valid_q))
		else $error("admitted slot was released");

	a_grant_needs_process: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsa_pkg::S_COMMIT && func_q == bsa_pkg::FN_REQUEST)
			|-> (in_range && slot_valid_q[slot_idx] && (&done_q)))
		else $error("request granted without an admitted process and a full finish order");
`endif

endmodule

// ===== test/bankers_safe_allocator_tb.sv =====
// self-checking testbench for the three-resource banker's allocator
`timescale 1ns / 100ps

module bankers_safe_allocator_tb;
	import bsa_pkg::*;

	typedef logic [2:0][7:0] triple_t;

	localparam int NumSlots    = 8;
	localparam int PhaseItems  = 256;
	localparam int NumPhases   = 6;
	localparam int StallLimit  = 2000;
	localparam int SettleCycles = 100;

	class alloc_scoreboard;
		triple_t     avail;
		triple_t     alloc_t [NumSlots];
		triple_t     need_t [NumSlots];
		bit          used [NumSlots];
		logic [31:0] result_q [$];
		int          mismatches;

		function new();
			int p;
			avail = {8'(InitAvailR3), 8'(InitAvailR2), 8'(InitAvailR1)};
			mismatches = 0;
			for (p = 0; p < NumSlots; p++) begin
				used[p] = 1'b0;
				alloc_t[p] = '0;
				need_t[p] = '0;
			end
		endfunction

		function void load_reg(int idx, logic [7:0] val);
			avail[idx] = val;
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		// look for a finish order with the request already granted on paper
		function bit trial_safe(int s, triple_t req);
			int      work [3];
			triple_t need_w [NumSlots];
			bit      done [NumSlots];
			bit      progress;
			bit      fits;
			int      p;
			int      r;
			int      round;
			for (r = 0; r < 3; r++)
				work[r] = int'(avail[r]) - int'(req[r]);
			for (p = 0; p < NumSlots; p++) begin
				done[p] = !used[p];
				need_w[p] = need_t[p];
			end
			for (r = 0; r < 3; r++)
				need_w[s][r] = need_w[s][r] - req[r];
			for (round = 0; round < NumSlots; round++) begin
				progress = 1'b0;
				for (p = 0; p < NumSlots; p++) begin
					fits = 1'b1;
					for (r = 0; r < 3; r++)
						if (work[r] < int'(need_w[p][r]))
							fits = 1'b0;
					if (!done[p] && fits) begin
						for (r = 0; r < 3; r++) begin
							work[r] = work[r] + int'(alloc_t[p][r]);
							if (p == s)
								work[r] = work[r] + int'(req[r]);
						end
						done[p] = 1'b1;
						progress = 1'b1;
					end
				end
				if (!progress)
					break;
			end
			for (p = 0; p < NumSlots; p++)
				if (!done[p])
					return 1'b0;
			return 1'b1;
		endfunction

		function status_t admit(int s, triple_t amt, triple_t mx);
			int r;
			if (used[s])
				return ST_SLOT_BUSY;
			for (r = 0; r < 3; r++)
				if (mx[r] < amt[r])
					return ST_EXCEEDS_NEED;
			for (r = 0; r < 3; r++)
				if (avail[r] < amt[r])
					return ST_ADMIT_SHORT;
			for (r = 0; r < 3; r++) begin
				alloc_t[s][r] = amt[r];
				need_t[s][r] = mx[r] - amt[r];
				avail[r] = avail[r] - amt[r];
			end
			used[s] = 1'b1;
			return ST_OK;
		endfunction

		function status_t request(int s, triple_t req);
			int r;
			if (!used[s])
				return ST_NO_PROC;
			for (r = 0; r < 3; r++)
				if (need_t[s][r] < req[r])
					return ST_EXCEEDS_NEED;
			for (r = 0; r < 3; r++)
				if (avail[r] < req[r])
					return ST_EXCEEDS_AVAIL;
			if (!trial_safe(s, req))
				return ST_UNSAFE;
			for (r = 0; r < 3; r++) begin
				alloc_t[s][r] = alloc_t[s][r] + req[r];
				need_t[s][r] = need_t[s][r] - req[r];
				avail[r] = avail[r] - req[r];
			end
			return ST_OK;
		endfunction

		function void note_item(func_t fn, logic [2:0] slot, triple_t amt, triple_t mx);
			status_t st;
			if (fn == FN_ADMIT)
				st = admit(int'(slot), amt, mx);
			else
				st = request(int'(slot), amt);
			result_q.push_back({5'b0, avail, st});
		endfunction

		function void check_beat(logic [31:0] got);
			logic [31:0] want;
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			want = result_q.pop_front();
			if (got[2:0] !== want[2:0] || got[10:3] !== want[10:3] ||
					got[18:11] !== want[18:11] || got[26:19] !== want[26:19]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("bad result beat: status exp %0d got %0d, avail exp %0d/%0d/%0d got %0d/%0d/%0d",
						want[2:0], got[2:0], want[10:3], want[18:11], want[26:19],
						got[10:3], got[18:11], got[26:19]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// slot[2:0], amt_r1[10:3], amt_r2[18:11], amt_r3[26:19],
	// max_r1[34:27], max_r2[42:35], max_r3[50:43], zero pad[55:51]
	logic [55:0] s_tdata = '0;
	// func[0]
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status[2:0], avail_r1[10:3], avail_r2[18:11], avail_r3[26:19], zero pad[31:27]
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	alloc_scoreboard sb = new();

	logic [15:0] ready_pat = '1;
	int          pat_left = 0;
	int          stall_cycles = 0;
	int          burst_left = 1;
	bit          calm = 1'b1;
	bit          held = 1'b0;

	bankers_safe_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// receiver backpressure, from a random ready pattern that rotates and is redrawn when its counter runs out
	always @(posedge clk) begin
		if (pat_left == 0) begin
			pat_left <= 64;
			if ($urandom_range(0, 3) == 0)
				ready_pat <= '1;
			else
				ready_pat <= 16'($urandom_range(0, 65535)) | 16'h0101;
		end else begin
			pat_left <= pat_left - 1;
			ready_pat <= {ready_pat[14:0], ready_pat[15]};
		end
		m_tready <= ready_pat[0];
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic triple_t res3(int r1, int r2, int r3);
		return {8'(r3), 8'(r2), 8'(r1)};
	endfunction

	function automatic int lesser(int a, int b);
		return (a < b) ? a : b;
	endfunction

	task automatic send(func_t fn, logic [2:0] slot, triple_t amt, triple_t mx);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {5'b0, mx, amt, slot};
		held = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(fn, slot, amt, mx);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = calm ? 0 : $urandom_range(0, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				held = 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	endtask

	task automatic drain();
		if (held) begin
			s_tvalid <= 1'b0;
			held = 1'b0;
		end
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [7:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.load_reg(int'(idx), val);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_avail_load(int phase);
		int k;
		if (phase == 1)
			return 8'd255;
		if (phase == 2)
			return 8'd0;
		k = $urandom_range(0, 19);
		if (k < 2)
			return 8'd0;
		if (k < 4)
			return 8'd255;
		if (k < 10)
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic pick_item(output func_t fn, output logic [2:0] slot,
			output triple_t amt, output triple_t mx);
		int kind;
		int start;
		int idx;
		int free_slot;
		int busy_slot;
		int i;
		int r;
		int bound;
		kind = $urandom_range(0, 99);
		start = $urandom_range(0, NumSlots - 1);
		free_slot = -1;
		busy_slot = -1;
		for (i = 0; i < NumSlots; i++) begin
			idx = (start + i) % NumSlots;
			if (!sb.used[idx] && free_slot < 0)
				free_slot = idx;
			if (sb.used[idx] && busy_slot < 0)
				busy_slot = idx;
		end
		fn = FN_REQUEST;
		slot = 3'($urandom_range(0, NumSlots - 1));
		for (r = 0; r < 3; r++) begin
			amt[r] = 8'($urandom_range(0, 255));
			mx[r] = 8'($urandom_range(0, 255));
		end
		if (kind < 50 && free_slot >= 0) begin
			fn = FN_ADMIT;
			slot = 3'(free_slot);
			for (r = 0; r < 3; r++) begin
				mx[r] = 8'($urandom_range(0, 40));
				amt[r] = 8'($urandom_range(0, lesser(int'(mx[r]), int'(sb.avail[r]))));
			end
		end else if (kind < 88 && busy_slot >= 0) begin
			slot = 3'(busy_slot);
			for (r = 0; r < 3; r++)
				amt[r] = 8'($urandom_range(0,
					lesser(int'(sb.need_t[busy_slot][r]), int'(sb.avail[r]))));
			// overshoot need or available on one resource
			if (kind >= 80) begin
				r = $urandom_range(0, 2);
				if ($urandom_range(0, 1) == 0)
					bound = int'(sb.need_t[busy_slot][r]);
				else
					bound = int'(sb.avail[r]);
				amt[r] = 8'(lesser(255, bound + $urandom_range(1, 3)));
			end
		end else if (kind >= 95) begin
			fn = FN_ADMIT;
		end
	endtask

	initial begin
		func_t      fn;
		logic [2:0] slot;
		triple_t    amt;
		triple_t    mx;
		int         phase;
		int         n;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// directed items on the reset loads of 9/3/6
		send(FN_REQUEST, 3'd0, res3(0, 0, 0), res3(0, 0, 0));
		send(FN_ADMIT, 3'd0, res3(0, 1, 0), res3(7, 2, 3));
		send(FN_ADMIT, 3'd0, res3(1, 1, 1), res3(2, 2, 2));
		send(FN_ADMIT, 3'd1, res3(4, 0, 0), res3(3, 2, 2));
		send(FN_ADMIT, 3'd1, res3(255, 255, 255), res3(255, 255, 255));
		send(FN_ADMIT, 3'd1, res3(2, 0, 0), res3(3, 2, 2));
		send(FN_ADMIT, 3'd2, res3(3, 0, 2), res3(9, 0, 2));
		send(FN_ADMIT, 3'd3, res3(2, 1, 1), res3(2, 2, 2));
		send(FN_ADMIT, 3'd4, res3(0, 0, 2), res3(0, 1, 2));
		send(FN_ADMIT, 3'd7, res3(0, 0, 0), res3(0, 0, 0));
		send(FN_REQUEST, 3'd0, res3(8, 0, 0), res3(0, 0, 0));
		send(FN_REQUEST, 3'd1, res3(1, 0, 2), res3(0, 0, 0));
		send(FN_REQUEST, 3'd4, res3(0, 1, 0), res3(0, 0, 0));
		send(FN_REQUEST, 3'd0, res3(2, 0, 0), res3(0, 0, 0));
		send(FN_REQUEST, 3'd3, res3(0, 0, 1), res3(0, 0, 0));
		send(FN_REQUEST, 3'd2, res3(255, 0, 0), res3(255, 255, 255));
		send(FN_REQUEST, 3'd1, res3(0, 0, 0), res3(0, 0, 0));
		send(FN_REQUEST, 3'd6, res3(255, 255, 255), res3(255, 255, 255));
		send(FN_ADMIT, 3'd7, res3(255, 255, 255), res3(255, 255, 255));

		for (phase = 0; phase < NumPhases; phase++) begin
			if (phase > 0) begin
				drain();
				cfg_write(REG_INIT_R1, pick_avail_load(phase));
				cfg_write(REG_INIT_R2, pick_avail_load(phase));
				cfg_write(REG_INIT_R3, pick_avail_load(phase));
			end
			calm = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PhaseItems; n++) begin
				pick_item(fn, slot, amt, mx);
				send(fn, slot, amt, mx);
			end
		end

		drain();
		repeat (SettleCycles)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== bankers_safe_allocator.f =====
rtl/core/bsa_pkg.sv
rtl/core/bankers_safe_allocator.sv
test/bankers_safe_allocator_tb.sv
